>>> rtl/core/assert_macros.svh
// Assertion macros used by the heater controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/hscc_pkg.sv
// Package: widths, codes, constants and helper functions of the heater controller.
`default_nettype none

package hscc_pkg;

   localparam int SAMPLES_PER_AVERAGE = 20;
   localparam int PWM_PERIOD          = 40;

   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int CHAN_W    = 2;
   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = 17;
   localparam int TALLY_W   = 5;
   localparam int PHASE_W   = 6;
   localparam int FRAME_W   = 3;
   localparam int DUTY_W    = 7;
   localparam int CHANNELS  = 4;
   localparam int CSR_INDEX_W = 1;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [TALLY_W-1:0]  tally_type;
   typedef logic [PHASE_W-1:0]  phase_type;
   typedef logic [FRAME_W-1:0]  frame_type;
   typedef logic [DUTY_W-1:0]   duty_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Item kinds
   localparam kind_type KIND_SPI  = 2'd0;
   localparam kind_type KIND_ADC  = 2'd1;
   localparam kind_type KIND_TICK = 2'd2;

   // SPI commands
   localparam byte_type CMD_STATUS   = 8'd1;
   localparam byte_type CMD_SET_ODD  = 8'd2;
   localparam byte_type CMD_PROBE    = 8'd3;
   localparam byte_type CMD_SET_EVEN = 8'd7;

   // Preload values
   localparam byte_type PRELOAD_ZERO = 8'd0;
   localparam byte_type PRELOAD_ACK  = 8'd3;

   // Frame positions
   localparam frame_type FRAME_IDLE  = 3'd0;
   localparam frame_type FRAME_BYTE1 = 3'd1;
   localparam frame_type FRAME_BYTE2 = 3'd2;
   localparam frame_type FRAME_BYTE3 = 3'd3;
   localparam frame_type FRAME_BYTE4 = 3'd4;

   // Configuration register indexes
   localparam csr_index_type CSR_VERSION = 1'd0;
   localparam csr_index_type CSR_PROBE   = 1'd1;

   localparam byte_type VERSION_RESET = 8'd7;
   localparam byte_type PROBE_RESET   = 8'd2;
   localparam byte_type CURRENT_RESET [CHANNELS] = '{8'd15, 8'd25, 8'd35, 8'd45};

   localparam tally_type TALLY_LIMIT = TALLY_W'(SAMPLES_PER_AVERAGE);
   localparam phase_type PHASE_LAST  = PHASE_W'(PWM_PERIOD - 1);

   // Current scaling: floor(sum * 99 / (4096 * N)) through a ceiling reciprocal
   localparam longint CURRENT_GAIN   = 99;
   localparam longint ADC_FULL_SCALE = 4096;
   localparam longint AVG_DIVISOR    = ADC_FULL_SCALE * SAMPLES_PER_AVERAGE;
   localparam longint PROD_MAX       = ((longint'(1) << SUM_W) - 1) * CURRENT_GAIN;
   localparam int     PROD_W         = $clog2(PROD_MAX + 1);
   localparam int     AVG_SHIFT      = PROD_W + $clog2(AVG_DIVISOR);
   localparam longint AVG_RECIP      =
      ((longint'(1) << AVG_SHIFT) + AVG_DIVISOR - 1) / AVG_DIVISOR;
   localparam int     RECIP_W        = $clog2(AVG_RECIP + 1);
   localparam int     SCALED_W       = PROD_W + RECIP_W;

   typedef logic [PROD_W-1:0] prod_type;

   // Duty: floor(setting * 2 / 5) as (setting * 410) >> 10, exact for 8-bit settings
   localparam int DUTY_MUL   = 410;
   localparam int DUTY_SHIFT = 10;
   localparam int DUTY_P_W   = 17;

   function automatic duty_type duty_of(input byte_type setting);
      logic [DUTY_P_W-1:0] p;
      p = DUTY_P_W'(setting) * DUTY_P_W'(DUTY_MUL);
      return DUTY_W'(p >> DUTY_SHIFT);
   endfunction

   function automatic byte_type current_of(input prod_type prod);
      logic [SCALED_W-1:0] scaled;
      scaled = SCALED_W'(prod) * SCALED_W'(AVG_RECIP);
      return BYTE_W'(scaled >> AVG_SHIFT);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/hscc_channels.sv
// Interfaces: request and response channels of the heater controller.
`default_nettype none

interface hscc_req_if import hscc_pkg::*; ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   byte_type   rx_byte;
   chan_type   adc_channel;
   sample_type adc_sample;

   modport source (output valid, output kind, output rx_byte, output adc_channel,
                   output adc_sample, input ready);
   modport sink   (input valid, input kind, input rx_byte, input adc_channel,
                   input adc_sample, output ready);
endinterface

interface hscc_rsp_if import hscc_pkg::*; ();
   logic                valid;
   logic                ready;
   byte_type            tx_byte;
   logic                tx_renewed;
   logic [CHANNELS-1:0] heater_levels;
   logic                current_updated;

   modport source (output valid, output tx_byte, output tx_renewed,
                   output heater_levels, output current_updated, input ready);
   modport sink   (input valid, input tx_byte, input tx_renewed,
                   input heater_levels, input current_updated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/heater_spi_command_controller_core.sv
// Top level: SPI command decoder, ADC averaging and PWM heater outputs.
// A request word is registered in the input stage, then executes into the response register.
// Throughput: one word per cycle while responses drain, set by the single execute stage that
// updates the controller state. An averaged current byte passes the pending-average register
// on its way; a read while it is pending takes the forwarded value, so no word ever waits for it.
// Reset (synchronous, active high) restores the control state and empties all pipeline stages.
`default_nettype none
`include "assert_macros.svh"

module heater_spi_command_controller_core import hscc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   hscc_req_if.sink           req_bus,
   hscc_rsp_if.source         rsp_bus,
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire byte_type      csr_write_data
);

   // Configuration registers
   byte_type version_ff, version_in;
   byte_type probe_ff,   probe_in;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   kind_type   in_kind_ff;
   byte_type   in_rx_ff;
   chan_type   in_chan_ff;
   sample_type in_sample_ff;

   // Controller state
   frame_type frame_ff,   frame_in;
   byte_type  command_ff, command_in;
   byte_type  preload_ff, preload_in;
   phase_type phase_ff,   phase_in;
   duty_type  duty_ff    [CHANNELS];
   duty_type  duty_in    [CHANNELS];
   byte_type  current_ff [CHANNELS];
   byte_type  current_in [CHANNELS];
   sum_type   sum_ff     [CHANNELS];
   sum_type   sum_in     [CHANNELS];
   tally_type tally_ff   [CHANNELS];
   tally_type tally_in   [CHANNELS];

   // Average in flight: scaled product waiting for its final divide
   logic     pend_valid_ff, pend_valid_in;
   chan_type pend_chan_ff,  pend_chan_in;
   prod_type pend_prod_ff,  pend_prod_in;
   byte_type pend_current;
   byte_type current_fwd [CHANNELS];

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   byte_type            rsp_tx_ff;
   logic                rsp_renewed_ff, rsp_renewed_in;
   logic [CHANNELS-1:0] rsp_levels_ff,  rsp_levels_in;
   logic                rsp_updated_ff, rsp_updated_in;

   logic advance;
   logic exec_fire;
   logic req_fire;
   logic tally_ok;

   // Pipeline control: the execute stage moves whenever the response register frees up
   assign advance   = !rsp_valid_ff || rsp_bus.ready;
   assign exec_fire = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire  = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (exec_fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = exec_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Configuration writes
   always_comb begin
      version_in = version_ff;
      probe_in   = probe_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VERSION: version_in = csr_write_data;
            CSR_PROBE:   probe_in   = csr_write_data;
            default:     ;
         endcase
      end
   end

   // Finish the divide of the pending average and forward it to readers
   assign pend_current = current_of(pend_prod_ff);

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         current_in[k]  = current_ff[k];
         current_fwd[k] = current_ff[k];
         if (pend_valid_ff && pend_chan_ff == CHAN_W'(k)) begin
            current_in[k]  = pend_current;
            current_fwd[k] = pend_current;
         end
      end
   end

   // Execute: one item updates the state and builds its response word
   always_comb begin
      frame_type pos;
      sum_type   total;
      tally_type tally_next;

      pos        = frame_ff + FRAME_W'(1);
      total      = sum_ff[in_chan_ff] + SUM_W'(in_sample_ff);
      tally_next = tally_ff[in_chan_ff] + TALLY_W'(1);

      frame_in       = frame_ff;
      command_in     = command_ff;
      preload_in     = preload_ff;
      phase_in       = phase_ff;
      duty_in        = duty_ff;
      sum_in         = sum_ff;
      tally_in       = tally_ff;
      pend_valid_in  = 1'b0;
      pend_chan_in   = in_chan_ff;
      pend_prod_in   = PROD_W'(PROD_W'(total) * PROD_W'(CURRENT_GAIN));
      rsp_renewed_in = 1'b0;
      rsp_updated_in = 1'b0;

      if (exec_fire) begin
         unique case (in_kind_ff)
            KIND_SPI: begin
               frame_in = pos;
               unique case (pos)
                  FRAME_BYTE1: begin
                     // Status and odd-channel write commands answer with zero, all others with the version
                     preload_in = (command_ff == CMD_STATUS || command_ff == CMD_SET_ODD)
                                  ? PRELOAD_ZERO : version_ff;
                     rsp_renewed_in = 1'b1;
                  end
                  FRAME_BYTE2: begin
                     command_in = in_rx_ff;
                     unique case (in_rx_ff) inside
                        CMD_STATUS: begin
                           preload_in = PRELOAD_ZERO;
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_SET_ODD: begin
                           preload_in = PRELOAD_ACK;
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_PROBE: begin
                           preload_in = probe_ff;
                           rsp_renewed_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  FRAME_BYTE3: begin
                     unique case (command_ff) inside
                        CMD_STATUS, CMD_PROBE: begin
                           preload_in = PRELOAD_ZERO;
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_SET_ODD: begin
                           duty_in[0] = duty_of(in_rx_ff);
                           preload_in = current_fwd[0];
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_SET_EVEN: begin
                           duty_in[1] = duty_of(in_rx_ff);
                           preload_in = current_fwd[1];
                           rsp_renewed_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  FRAME_BYTE4: begin
                     frame_in = FRAME_IDLE;
                     unique case (command_ff) inside
                        CMD_STATUS: begin
                           preload_in = PRELOAD_ZERO;
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_SET_ODD: begin
                           duty_in[2] = duty_of(in_rx_ff);
                           preload_in = current_fwd[2];
                           rsp_renewed_in = 1'b1;
                        end
                        CMD_SET_EVEN: begin
                           duty_in[3] = duty_of(in_rx_ff);
                           preload_in = current_fwd[3];
                           rsp_renewed_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  default: begin
                     // Out of frame: drop back to idle, renew nothing
                     frame_in = FRAME_IDLE;
                  end
               endcase
            end
            KIND_ADC: begin
               if (tally_next >= TALLY_LIMIT) begin
                  // Average complete: hand the product to the divide stage, clear the channel
                  sum_in[in_chan_ff]   = '0;
                  tally_in[in_chan_ff] = '0;
                  pend_valid_in  = 1'b1;
                  rsp_updated_in = 1'b1;
               end else begin
                  sum_in[in_chan_ff]   = total;
                  tally_in[in_chan_ff] = tally_next;
               end
            end
            KIND_TICK: begin
               phase_in = (phase_ff >= PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);
            end
            default: ;
         endcase
      end
   end

   // Heater levels from the updated duty and phase
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         rsp_levels_in[k] = DUTY_W'(phase_in) < duty_in[k];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff    <= VERSION_RESET;
         probe_ff      <= PROBE_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         frame_ff      <= FRAME_IDLE;
         command_ff    <= '0;
         preload_ff    <= '0;
         phase_ff      <= '0;
         for (int k = 0; k < CHANNELS; k++) begin
            duty_ff[k]    <= '0;
            current_ff[k] <= CURRENT_RESET[k];
            sum_ff[k]     <= '0;
            tally_ff[k]   <= '0;
         end
      end else begin
         version_ff    <= version_in;
         probe_ff      <= probe_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         frame_ff      <= frame_in;
         command_ff    <= command_in;
         preload_ff    <= preload_in;
         phase_ff      <= phase_in;
         duty_ff       <= duty_in;
         current_ff    <= current_in;
         sum_ff        <= sum_in;
         tally_ff      <= tally_in;
      end
   end

   // Payload registers: load on acceptance or execution, hold otherwise; the pending average loads every cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_bus.kind;
         in_rx_ff     <= req_bus.rx_byte;
         in_chan_ff   <= req_bus.adc_channel;
         in_sample_ff <= req_bus.adc_sample;
      end
      if (exec_fire) begin
         rsp_tx_ff      <= preload_in;
         rsp_renewed_ff <= rsp_renewed_in;
         rsp_levels_ff  <= rsp_levels_in;
         rsp_updated_ff <= rsp_updated_in;
      end
      pend_chan_ff <= pend_chan_in;
      pend_prod_ff <= pend_prod_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.tx_byte         = rsp_tx_ff;
   assign rsp_bus.tx_renewed      = rsp_renewed_ff;
   assign rsp_bus.heater_levels   = rsp_levels_ff;
   assign rsp_bus.current_updated = rsp_updated_ff;

   // Every channel's sample count stays below the averaging length
   assign tally_ok = tally_ff[0] < TALLY_LIMIT && tally_ff[1] < TALLY_LIMIT
                     && tally_ff[2] < TALLY_LIMIT && tally_ff[3] < TALLY_LIMIT;

   // Checks
   `ASSERT_NEXT(a_rsp_after_exec, clock, reset, exec_fire, rsp_valid_ff)
   `ASSERT_NEXT(a_pend_after_average, clock, reset, exec_fire && rsp_updated_in, pend_valid_ff)
   `ASSERT_IMPLIES(a_frame_in_range, clock, reset, 1'b1, frame_ff <= FRAME_BYTE3)
   `ASSERT_IMPLIES(a_phase_in_range, clock, reset, 1'b1, phase_ff <= PHASE_LAST)
   `ASSERT_IMPLIES(a_tally_in_range, clock, reset, 1'b1, tally_ok)

endmodule

`default_nettype wire
